// ===== rtl/afmr_pkg.sv =====
// ----------------------------------------------------------------------------
// afmr_pkg
// Shared types and arithmetic helpers for the approximate FP16 row accumulator.
// ----------------------------------------------------------------------------
package afmr_pkg;

  localparam logic [31:0] F32_QNAN = 32'h7FC00000;
  localparam logic [15:0] F16_QNAN = 16'h7E00;

  typedef struct packed {
    logic [26:0] big_mant;
    logic [26:0] sml_mant;
    logic [7:0]  exp;
    logic        sign;
    logic        sub;
    logic        nan;
    logic        inf;
    logic        inf_sign;
  } align_t;

  typedef struct packed {
    logic [27:0] sum;
    logic [7:0]  exp;
    logic        sign;
    logic        sub;
    logic        nan;
    logic        inf;
    logic        inf_sign;
  } sum_t;

  // Approximate FP16 product, returned as FP32.
  function automatic logic [31:0] approx_prod(input logic [15:0] a, input logic [15:0] b);
    logic [4:0]        ea;
    logic [4:0]        eb;
    logic              sgn;
    logic [7:0]        ma;
    logic [7:0]        mb;
    logic [3:0]        lo;
    logic [3:0]        hi;
    logic [11:0]       plo;
    logic [11:0]       phi;
    logic [15:0]       p1;
    logic [15:0]       p2;
    logic [19:0]       cmb;
    logic [7:0]        p;
    logic signed [7:0] e;
    logic [31:0]       r;
    ea  = a[14:10];
    eb  = b[14:10];
    sgn = a[15] ^ b[15];
    ma  = {1'b1, a[9:3]};
    mb  = {1'b1, b[9:3]};
    lo  = mb[3:0];
    hi  = mb[7:4];
    plo = {4'b0, ma} * {8'b0, lo};
    phi = {4'b0, ma} * {8'b0, hi};
    p1  = ({4'b0, plo} & 16'hFFF8) | {13'b0, ma[2:0] | lo[2:0]};
    p2  = ({4'b0, phi} & 16'hFF00) | {8'b0, ma | {4'b0, hi}};
    cmb = {4'b0, p1} | {p2, 4'b0};
    p   = cmb[15:8];
    e   = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 8'sd14;
    if (!p[7]) begin
      p = {p[6:0], 1'b0};
      e = e - 8'sd1;
    end
    if (ea == 5'd0 || eb == 5'd0) begin
      r = 32'b0;
    end else if (e <= 8'sd0) begin
      r = {sgn, 31'b0};
    end else if (e >= 8'sd31) begin
      r = {sgn, 8'hFF, 23'b0};
    end else begin
      r = {sgn, 8'(unsigned'(e)) + 8'd112, p[6:0], 16'b0};
    end
    return r;
  endfunction

  // FP32 to FP16, round to nearest even.
  function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
    logic              s;
    logic [7:0]        e8;
    logic [22:0]       m;
    logic signed [9:0] e;
    logic [14:0]       hn;
    logic [12:0]       remn;
    logic [9:0]        sh;
    logic [23:0]       mm;
    logic [23:0]       hs;
    logic [23:0]       rems;
    logic [23:0]       halfway;
    logic [15:0]       r;
    s  = x[31];
    e8 = x[30:23];
    m  = x[22:0];
    e  = $signed({2'b0, e8}) - 10'sd112;
    hn = {e[4:0], m[22:13]};
    remn = m[12:0];
    sh = 10'(unsigned'(10'sd14 - e));
    mm = {1'b1, m};
    hs = mm >> sh[4:0];
    rems = mm & ((24'd1 << sh[4:0]) - 24'd1);
    halfway = 24'd1 << (sh[4:0] - 5'd1);
    if (e8 == 8'hFF) begin
      r = (m != 23'd0) ? F16_QNAN : {s, 15'h7C00};
    end else if (e8 == 8'd0) begin
      r = {s, 15'b0};
    end else if (e >= 10'sd31) begin
      r = {s, 15'h7C00};
    end else if (e >= 10'sd1) begin
      if (remn > 13'h1000 || (remn == 13'h1000 && hn[0])) hn = hn + 15'd1;
      r = {s, hn};
    end else if (sh > 10'd24) begin
      r = {s, 15'b0};
    end else begin
      if (rems > halfway || (rems == halfway && hs[0])) hs = hs + 24'd1;
      r = {s, hs[14:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/afmr_if.sv =====
// ----------------------------------------------------------------------------
// afmr channel interfaces
// Valid/ready channels for operand beats and finished column sums.
// ----------------------------------------------------------------------------
interface afmr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] a_operand;
  logic [15:0] b_operand;
  logic [7:0]  column;
  logic        first_term;
  logic        last_term;
  modport source(output valid, a_operand, b_operand, column, first_term, last_term,
                 input ready);
  modport sink(input valid, a_operand, b_operand, column, first_term, last_term,
               output ready);
endinterface

interface afmr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_column;
  logic [15:0] sum_half;
  modport source(output valid, out_column, sum_half, input ready);
  modport sink(input valid, out_column, sum_half, output ready);
endinterface

// ===== rtl/afmr_ram.sv =====
// ----------------------------------------------------------------------------
// afmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/afmr_fadd.sv =====
// ----------------------------------------------------------------------------
// afmr_fadd
// FP32 adder: align stage, add stage, then normalize and round out of the
// add register.
// ----------------------------------------------------------------------------
module afmr_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [31:0] result
);
  afmr_pkg::align_t al_next;
  afmr_pkg::align_t al;
  afmr_pkg::sum_t   sm_next;
  afmr_pkg::sum_t   sm;

  logic        xnan, ynan, xinf, yinf, swap;
  logic [31:0] big, sml;
  logic [7:0]  d;
  logic [26:0] ext, shv;
  logic        stk;

  always_comb begin
    xnan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    ynan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    xinf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    yinf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    swap = y[30:0] > x[30:0];
    big  = swap ? y : x;
    sml  = swap ? x : y;
    d    = big[30:23] - sml[30:23];
    ext  = {sml[30:23] != 8'd0, sml[22:0], 3'b0};
    if (d >= 8'd27) begin
      shv = 27'd0;
      stk = |ext;
    end else begin
      shv = ext >> d;
      stk = |(ext & ~({27{1'b1}} << d));
    end
    al_next.big_mant = {big[30:23] != 8'd0, big[22:0], 3'b0};
    al_next.sml_mant = {shv[26:1], shv[0] | stk};
    al_next.exp      = big[30:23];
    al_next.sign     = big[31];
    al_next.sub      = x[31] ^ y[31];
    al_next.nan      = xnan | ynan | (xinf & yinf & (x[31] ^ y[31]));
    al_next.inf      = xinf | yinf;
    al_next.inf_sign = xinf ? x[31] : y[31];
  end

  always_comb begin
    sm_next.sum      = al.sub ? ({1'b0, al.big_mant} - {1'b0, al.sml_mant})
                              : ({1'b0, al.big_mant} + {1'b0, al.sml_mant});
    sm_next.exp      = al.exp;
    sm_next.sign     = al.sign;
    sm_next.sub      = al.sub;
    sm_next.nan      = al.nan;
    sm_next.inf      = al.inf;
    sm_next.inf_sign = al.inf_sign;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al <= al_next;
      sm <= sm_next;
    end
  end

  logic [4:0]        lz;
  logic [26:0]       n;
  logic signed [9:0] ex;
  logic              up;
  logic [30:0]       rr;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sm.sum[i]) lz = 5'(26 - i);
    end
    if (sm.sum[27]) begin
      n  = {sm.sum[27:2], sm.sum[1] | sm.sum[0]};
      ex = $signed({2'b0, sm.exp}) + 10'sd1;
    end else begin
      n  = sm.sum[26:0] << lz;
      ex = $signed({2'b0, sm.exp}) - $signed({5'b0, lz});
    end
    up = n[2] & (n[1] | n[0] | n[3]);
    rr = {ex[7:0], n[25:3]} + {30'b0, up};
    if (sm.nan) begin
      result = afmr_pkg::F32_QNAN;
    end else if (sm.inf) begin
      result = {sm.inf_sign, 8'hFF, 23'b0};
    end else if (sm.sum == 28'd0) begin
      result = {sm.sign & ~sm.sub, 31'b0};
    end else if (ex >= 10'sd255) begin
      result = {sm.sign, 8'hFF, 23'b0};
    end else if (ex <= 10'sd0) begin
      result = {sm.sign, 31'b0};
    end else begin
      result = {sm.sign, rr};
    end
  end
endmodule

// ===== rtl/approx_fp16_matmul_row_accumulator.sv =====
// ----------------------------------------------------------------------------
// approx_fp16_matmul_row_accumulator
// Approximate FP16 multiply with FP32 per-column accumulation.
// ----------------------------------------------------------------------------
// Input channel in_ch carries an FP16 operand pair, a column index and
// first/last flags; a beat is taken when valid and ready are both high.
// Each product is added into the FP32 accumulator of its column, held in a
// one-port-write, one-port-read RAM. first_term starts the column from zero.
// A beat with last_term set yields one beat on out_ch: the column and the
// sum rounded to FP16 (nearest even).
// Throughput: one beat per cycle while out_ch is not stalled and successive
// beats address different columns. A beat whose column is still in flight in
// the three stages between RAM read and write-back waits until the write
// lands, so beats that keep hitting one column each wait for the write before.
// A result passes the product/RAM read register, align, add, normalize/round
// with write-back, and FP16 convert into the output reg.
// Reset clears all pipeline valids and the output valid; the
// accumulators are not cleared and must be started with first_term.
// When out_ch stalls with a result held, the whole pipeline freezes and
// in_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module approx_fp16_matmul_row_accumulator #(
  parameter int MAX_COLUMNS = 256
) (
  input  logic      clk,
  input  logic      rst,
  afmr_in_if.sink   in_ch,
  afmr_out_if.source out_ch
);
  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic          en;
  logic          hazard;
  logic          accept;
  logic [AW-1:0] idx;
  logic [24:0]   wrem;

  always_comb begin
    wrem = {17'b0, in_ch.column};
    for (int k = 7; k >= 0; k--) begin
      if (wrem >= (25'(MAX_COLUMNS) << k)) wrem = wrem - (25'(MAX_COLUMNS) << k);
    end
    idx = wrem[AW-1:0];
  end

  logic          s1_valid, s2_valid, s3_valid, s4_valid;
  logic [AW-1:0] s1_idx, s2_idx, s3_idx;
  logic [7:0]    s1_col, s2_col, s3_col, s4_col;
  logic          s1_last, s2_last, s3_last, s4_last;
  logic          s1_first;
  logic [31:0]   s1_prod;
  logic [31:0]   s4_sum;
  logic [31:0]   rdata;
  logic [31:0]   acc;
  logic [31:0]   sum;

  assign en     = !out_ch.valid || out_ch.ready;
  assign hazard = (s1_valid && s1_idx == idx) || (s2_valid && s2_idx == idx) ||
                  (s3_valid && s3_idx == idx);
  assign in_ch.ready = en && !hazard;
  assign accept = in_ch.valid && in_ch.ready;

  afmr_ram #(.WIDTH(32), .DEPTH(MAX_COLUMNS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (en && s3_valid),
    .waddr (s3_idx),
    .wdata (sum),
    .re    (accept),
    .raddr (idx),
    .rdata (rdata)
  );

  assign acc = s1_first ? 32'b0 : rdata;

  afmr_fadd u_fadd (
    .clk    (clk),
    .en     (en),
    .x      (acc),
    .y      (s1_prod),
    .result (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      s1_valid     <= accept;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      out_ch.valid <= s4_valid && s4_last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx            <= idx;
      s1_col            <= in_ch.column;
      s1_first          <= in_ch.first_term;
      s1_last           <= in_ch.last_term;
      s1_prod           <= afmr_pkg::approx_prod(in_ch.a_operand, in_ch.b_operand);
      s2_idx            <= s1_idx;
      s2_col            <= s1_col;
      s2_last           <= s1_last;
      s3_idx            <= s2_idx;
      s3_col            <= s2_col;
      s3_last           <= s2_last;
      s4_col            <= s3_col;
      s4_last           <= s3_last;
      s4_sum            <= sum;
      out_ch.out_column <= s4_col;
      out_ch.sum_half   <= afmr_pkg::f32_to_f16(s4_sum);
    end
  end
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for approx_fp16_matmul_row_accumulator. Drives operand
// beats with directed corner cases and random row sequences over eight main
// columns. A bit-exact predictor models the approximate FP16 product, the
// FP32 per-column sums and the FP16 rounding. Finished sums are checked in
// order against the predicted ones.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [31:0] SUM_NAN = 32'h7FC00000;

  typedef struct {
    logic [7:0]  column;
    logic [15:0] sum_half;
  } col_result_t;

  logic clk;
  logic rst;
  afmr_in_if  in_ch();
  afmr_out_if out_ch();

  approx_fp16_matmul_row_accumulator u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  col_result_t pending_sums[$];
  logic [31:0] col_acc[256];
  bit          col_live[256];
  int          mismatches = 0;
  int          cycles = 0;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] approx_mant(logic [7:0] ma, logic [7:0] mb);
    logic [31:0] lo, hi, p1, p2, cmb;
    lo  = mb & 8'h0F;
    hi  = (mb >> 4) & 8'h0F;
    p1  = ((ma * lo) & 32'hFFF8) | ((ma & 32'h07) | (lo & 32'h07));
    p2  = ((ma * hi) & 32'hFF00) | (ma | hi);
    cmb = p1 | (p2 << 4);
    return cmb[15:8];
  endfunction

  function automatic logic [31:0] approx_product(logic [15:0] a, logic [15:0] b);
    logic [7:0] p;
    int         e;
    logic       sgn;
    sgn = a[15] ^ b[15];
    if (a[14:10] == 5'd0 || b[14:10] == 5'd0) return 32'h0;
    p = approx_mant({1'b1, a[9:3]}, {1'b1, b[9:3]});
    e = int'(a[14:10]) + int'(b[14:10]) - 14;
    if (!p[7]) begin
      p = {p[6:0], 1'b0};
      e = e - 1;
    end
    if (e <= 0) return {sgn, 31'h0};
    if (e >= 31) return {sgn, 8'hFF, 23'h0};
    return {sgn, 8'(e + 112), p[6:0], 16'h0};
  endfunction

  function automatic real f32_as_real(logic [31:0] x);
    logic [10:0] e11;
    if (x[30:23] == 8'd0) return $bitstoreal({x[31], 63'h0});
    e11 = 11'(int'(x[30:23]) - 127 + 1023);
    return $bitstoreal({x[31], e11, x[22:0], 29'h0});
  endfunction

  // Double sum of two floats, rounded once more to FP32 (exact for add).
  function automatic logic [31:0] f32_add(logic [31:0] x, logic [31:0] y);
    logic        xi, yi;
    logic [63:0] d;
    logic [28:0] rem;
    logic [30:0] mag;
    int          e8;
    xi = (x[30:23] == 8'hFF);
    yi = (y[30:23] == 8'hFF);
    if ((xi && x[22:0] != 0) || (yi && y[22:0] != 0)) return SUM_NAN;
    if (xi && yi) return (x[31] == y[31]) ? x : SUM_NAN;
    if (xi) return x;
    if (yi) return y;
    d = $realtobits(f32_as_real(x) + f32_as_real(y));
    if (d[62:0] == 63'h0) return {d[63], 31'h0};
    e8 = int'(d[62:52]) - 1023 + 127;
    if (e8 >= 255) return {d[63], 8'hFF, 23'h0};
    if (e8 <= 0) return {d[63], 31'h0};
    mag = {8'(e8), d[51:29]};
    rem = d[28:0];
    if (rem > 29'h10000000 || (rem == 29'h10000000 && mag[0])) mag = mag + 31'd1;
    if (mag[30:23] == 8'hFF) return {d[63], 8'hFF, 23'h0};
    return {d[63], mag};
  endfunction

  function automatic logic [15:0] round_to_half(logic [31:0] x);
    logic [15:0] s;
    logic [31:0] m, half, rem, halfway;
    int          e, sh;
    s = {x[31], 15'h0};
    m = {9'h0, x[22:0]};
    if (x[30:23] == 8'hFF) return (m != 0) ? 16'h7E00 : (s | 16'h7C00);
    if (x[30:23] == 8'h00) return s;
    e = int'(x[30:23]) - 112;
    if (e >= 31) return s | 16'h7C00;
    if (e >= 1) begin
      half = (e << 10) | (m >> 13);
      rem  = m & 32'h1FFF;
      if (rem > 32'h1000 || (rem == 32'h1000 && half[0])) half = half + 1;
      return s | half[15:0];
    end
    sh = 14 - e;
    if (sh > 24) return s;
    m = m | 32'h00800000;
    half = m >> sh;
    rem = m & ((32'd1 << sh) - 1);
    halfway = 32'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && half[0])) half = half + 1;
    return s | half[15:0];
  endfunction

  task automatic send_pair(logic [15:0] a, logic [15:0] b, logic [7:0] col,
                           logic first, logic last);
    logic [31:0] acc;
    int          n;
    in_ch.valid      <= 1'b1;
    in_ch.a_operand  <= a;
    in_ch.b_operand  <= b;
    in_ch.column     <= col;
    in_ch.first_term <= first;
    in_ch.last_term  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    acc = (first || !col_live[col]) ? 32'h0 : col_acc[col];
    acc = f32_add(acc, approx_product(a, b));
    col_acc[col]  = acc;
    col_live[col] = 1'b1;
    if (last) pending_sums.push_back('{column: col, sum_half: round_to_half(acc)});
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    int n;
    out_ch.ready <= 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    col_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sum: col %0d sum %h", out_ch.out_column, out_ch.sum_half);
      end else begin
        want = pending_sums.pop_front();
        if (out_ch.out_column !== want.column || out_ch.sum_half !== want.sum_half) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sum mismatch: exp col %0d sum %h, got col %0d sum %h",
                     want.column, want.sum_half, out_ch.out_column, out_ch.sum_half);
        end
      end
    end
  end

  function automatic logic [15:0] rand_half(bit wide);
    if (wide) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
  endfunction

  task automatic test_special_cases();
    send_pair(16'h3C00, 16'h3C00, 8'd0, 1'b1, 1'b1);
    send_pair(16'h0001, 16'hBC00, 8'd1, 1'b1, 1'b1);  // zero exponent
    send_pair(16'hBC00, 16'h03FF, 8'd1, 1'b1, 1'b1);
    send_pair(16'h8400, 16'h0400, 8'd2, 1'b1, 1'b1);  // underflow
    send_pair(16'h7C00, 16'h3C00, 8'd3, 1'b1, 1'b0);  // overflow to inf
    send_pair(16'hFC00, 16'h3C00, 8'd3, 1'b0, 1'b1);  // inf minus inf
    send_pair(16'h7E55, 16'h0400, 8'd4, 1'b1, 1'b1);  // exponent 31 as number
    send_pair(16'hFFFF, 16'h07FF, 8'd4, 1'b1, 1'b1);
    send_pair(16'h7BFF, 16'h3800, 8'd5, 1'b1, 1'b0);  // sum near the FP16 range top
    send_pair(16'h7BFF, 16'h3800, 8'd5, 1'b0, 1'b1);
    send_pair(16'h0C10, 16'h3200, 8'd6, 1'b1, 1'b0);  // products flush to zero
    send_pair(16'h8C00, 16'h3200, 8'd6, 1'b0, 1'b1);
    send_pair(16'h3FFF, 16'h3FFF, 8'd255, 1'b1, 1'b0);
    send_pair(16'hBFFF, 16'h4000, 8'd254, 1'b1, 1'b0);
    send_pair(16'h3555, 16'h2AAA, 8'd255, 1'b0, 1'b0);
    send_pair(16'h5A5A, 16'hA5A5, 8'd254, 1'b0, 1'b1);
    send_pair(16'h0000, 16'hFFFF, 8'd255, 1'b0, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 8'd128, 1'b1, 1'b1);
  endtask

  task automatic test_rows(int count);
    logic [7:0] cols[8];
    logic [7:0] c;
    logic       first;
    foreach (cols[i]) cols[i] = 8'($urandom);
    repeat (count) begin
      c = (($urandom_range(0, 9) == 0)) ? 8'($urandom) : cols[$urandom_range(0, 7)];
      first = !col_live[c] || ($urandom_range(0, 5) == 0);
      send_pair(rand_half($urandom_range(0, 3) == 0), rand_half($urandom_range(0, 3) == 0),
                c, first, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int guard;
    gaps_on = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.a_operand <= '0;
    in_ch.b_operand <= '0;
    in_ch.column <= '0;
    in_ch.first_term <= 1'b0;
    in_ch.last_term <= 1'b0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_rows(320);
    gaps_on = 1'b0;
    test_rows(110);
    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_sums.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/afmr_pkg.sv
rtl/afmr_if.sv
rtl/afmr_ram.sv
rtl/afmr_fadd.sv
rtl/approx_fp16_matmul_row_accumulator.sv
tb/tb.sv
